[design/spd_pkg.sv]
// shared types and constants of the sensor packet deframer
package spd_pkg;

    localparam int PACKET_BYTES = 10;
    localparam int VALUE_DIGITS = 5;
    localparam int HIST_BYTES   = PACKET_BYTES - 1;
    localparam int CODE_POS     = 3;
    localparam int VALUE_POS    = 4;

    localparam int CH_W     = 2;
    localparam int FILL_W   = 4;
    localparam int KIND_W   = 4;
    localparam int VAL_W    = 17;
    localparam int RAW_W    = 18;
    localparam int DIFF_W   = 19;
    localparam int SCALED_W = 26;
    localparam int OFFSET_W = 16;
    localparam int GAIN_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [7:0] byte_t;

    localparam byte_t CHAR_A     = 8'h61;
    localparam byte_t CHAR_B     = 8'h62;
    localparam byte_t CHAR_BANG  = 8'h21;
    localparam byte_t CHAR_PLUS  = 8'h2b;
    localparam byte_t CHAR_MINUS = 8'h2d;
    localparam byte_t CHAR_ZERO  = 8'h30;
    localparam byte_t CHAR_NINE  = 8'h39;
    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_TAB   = 8'h09;
    localparam byte_t CHAR_CR    = 8'h0d;
    localparam byte_t CODE_TEMP  = 8'h31;
    localparam byte_t CODE_ACCEL = 8'h32;
    localparam byte_t CODE_DIST  = 8'h34;
    localparam byte_t CODE_RAD   = 8'h35;
    localparam byte_t CODE_HUMID = 8'h36;
    localparam byte_t CODE_VOLT  = 8'h37;
    localparam byte_t CODE_LVOLT = 8'h41;
    localparam byte_t CODE_LCURR = 8'h42;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_TEMP    = 4'd0;
    localparam kind_t KIND_ACCEL   = 4'd1;
    localparam kind_t KIND_DIST    = 4'd2;
    localparam kind_t KIND_RAD     = 4'd3;
    localparam kind_t KIND_HUMID   = 4'd4;
    localparam kind_t KIND_VOLT    = 4'd5;
    localparam kind_t KIND_LVOLT   = 4'd6;
    localparam kind_t KIND_LCURR   = 4'd7;
    localparam kind_t KIND_UNKNOWN = 4'd8;

    localparam logic [OFFSET_W-1:0] RESET_OFFSET = 16'd323;
    localparam logic [GAIN_W-1:0]   RESET_GAIN   = 8'd24;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]               channel;
        byte_t                         code;
        byte_t [VALUE_DIGITS-1:0]      chars;
    } frame_t;

endpackage

[design/spd_in_if.sv]
// input channel: one tagged serial byte per item
interface spd_in_if;
    import spd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [7:0]        data_byte;

    modport source (output valid, output channel, output data_byte, input ready);
    modport sink   (input valid, input channel, input data_byte, output ready);
endinterface

[design/spd_out_if.sv]
// output channel: one decoded sensor packet per item
interface spd_out_if;
    import spd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            out_channel;
    logic [7:0]                 sensor_code;
    logic [KIND_W-1:0]          sensor_kind;
    logic signed [RAW_W-1:0]    raw_value;
    logic signed [SCALED_W-1:0] scaled_value;
    logic                       recorded;

    modport source (output valid, output out_channel, output sensor_code,
                    output sensor_kind, output raw_value, output scaled_value,
                    output recorded, input ready);
    modport sink   (input valid, input out_channel, input sensor_code,
                    input sensor_kind, input raw_value, input scaled_value,
                    input recorded, output ready);
endinterface

[design/spd_cell.sv]
// one window position: holds the byte of every channel at that place
module spd_cell #(
    parameter int CHANNELS = 3,
    parameter int CH_IDX_W = 2
) (
    input  logic                clk,
    input  logic                shift_en,
    input  logic [CH_IDX_W-1:0] ch_idx,
    input  spd_pkg::byte_t      din,
    output spd_pkg::byte_t      dout
);
    import spd_pkg::*;

    byte_t bytes_reg [CHANNELS];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            bytes_reg[ch_idx] <= din;
        end
    end

    assign dout = bytes_reg[ch_idx];

endmodule

[design/spd_post.sv]
// packet back end: value parse, kind decode, rescale and output register
module spd_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    output logic                          frame_ready,
    input  spd_pkg::frame_t               frame,
    input  logic [spd_pkg::OFFSET_W-1:0]  scale_offset,
    input  logic [spd_pkg::GAIN_W-1:0]    scale_gain,
    spd_out_if.source                     out
);
    import spd_pkg::*;

    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    function automatic kind_t kind_of(input byte_t code);
        kind_t k;
        case (code)
            CODE_TEMP:  k = KIND_TEMP;
            CODE_ACCEL: k = KIND_ACCEL;
            CODE_DIST:  k = KIND_DIST;
            CODE_RAD:   k = KIND_RAD;
            CODE_HUMID: k = KIND_HUMID;
            CODE_VOLT:  k = KIND_VOLT;
            CODE_LVOLT: k = KIND_LVOLT;
            CODE_LCURR: k = KIND_LCURR;
            default:    k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // strtol-like: skip spaces, optional sign, then digits until a non-digit
    function automatic logic signed [RAW_W-1:0] parse_value(
        input byte_t [VALUE_DIGITS-1:0] c
    );
        logic [1:0]           phase;
        logic                 neg;
        logic [VAL_W-1:0]     v;
        logic                 is_dig;
        logic                 is_sp;
        logic [RAW_W-1:0]     mag;
        phase = PH_LEAD;
        neg   = 1'b0;
        v     = '0;
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            is_dig = (c[i] >= CHAR_ZERO) && (c[i] <= CHAR_NINE);
            is_sp  = (c[i] == CHAR_SPACE) || ((c[i] >= CHAR_TAB) && (c[i] <= CHAR_CR));
            case (phase)
                PH_LEAD:
                begin
                    if (is_sp)
                    begin
                        phase = PH_LEAD;
                    end
                    else if ((c[i] == CHAR_PLUS) || (c[i] == CHAR_MINUS))
                    begin
                        neg   = (c[i] == CHAR_MINUS);
                        phase = PH_DIGITS;
                    end
                    else if (is_dig)
                    begin
                        v     = {13'b0, c[i][3:0]};
                        phase = PH_DIGITS;
                    end
                    else
                    begin
                        phase = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_dig)
                    begin
                        v = (v << 3) + (v << 1) + {13'b0, c[i][3:0]};
                    end
                    else
                    begin
                        phase = PH_DONE;
                    end
                end
                default:
                begin
                    phase = PH_DONE;
                end
            endcase
        end
        mag = {1'b0, v};
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

    // stage a: captured frame
    logic   a_valid_reg;
    frame_t a_frame_reg;

    // stage b: decoded fields
    logic                    b_valid_reg;
    logic [CH_W-1:0]         b_channel_reg;
    byte_t                   b_code_reg;
    kind_t                   b_kind_reg;
    logic signed [RAW_W-1:0] b_raw_reg;

    // output register
    logic                       o_valid_reg;
    logic [CH_W-1:0]            o_channel_reg;
    byte_t                      o_code_reg;
    kind_t                      o_kind_reg;
    logic signed [RAW_W-1:0]    o_raw_reg;
    logic signed [SCALED_W-1:0] o_scaled_reg;
    logic                       o_recorded_reg;

    logic o_free;
    logic b_free;
    logic a_free;

    assign o_free      = !o_valid_reg || out.ready;
    assign b_free      = !b_valid_reg || o_free;
    assign a_free      = !a_valid_reg || b_free;
    assign frame_ready = a_free;

    kind_t                    a_kind;
    byte_t [VALUE_DIGITS-1:0] a_chars;
    logic signed [RAW_W-1:0]  a_raw;

    always_comb
    begin
        a_kind = kind_of(a_frame_reg.code);
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            // temperature value characters arrive last digit first
            a_chars[i] = (a_kind == KIND_TEMP) ? a_frame_reg.chars[VALUE_DIGITS-1-i]
                                               : a_frame_reg.chars[i];
        end
        a_raw = parse_value(a_chars);
    end

    logic signed [DIFF_W-1:0]        b_diff;
    logic signed [DIFF_W+GAIN_W:0]   b_prod;
    logic signed [SCALED_W-1:0]      b_scaled;
    logic                            b_scale_sel;
    logic                            b_recorded;

    always_comb
    begin
        b_diff      = $signed({b_raw_reg[RAW_W-1], b_raw_reg})
                    - $signed({3'b000, scale_offset});
        b_prod      = b_diff * $signed({1'b0, scale_gain});
        b_scale_sel = (b_kind_reg == KIND_TEMP) || (b_kind_reg == KIND_ACCEL)
                   || (b_kind_reg == KIND_VOLT);
        b_recorded  = b_scale_sel || (b_kind_reg == KIND_HUMID);
        b_scaled    = b_scale_sel ? b_prod[SCALED_W-1:0]
                                  : {{(SCALED_W-RAW_W){b_raw_reg[RAW_W-1]}}, b_raw_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= frame_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (o_free)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && frame_valid)
        begin
            a_frame_reg <= frame;
        end
        if (b_free && a_valid_reg)
        begin
            b_channel_reg <= a_frame_reg.channel;
            b_code_reg    <= a_frame_reg.code;
            b_kind_reg    <= a_kind;
            b_raw_reg     <= a_raw;
        end
        if (o_free && b_valid_reg)
        begin
            o_channel_reg  <= b_channel_reg;
            o_code_reg     <= b_code_reg;
            o_kind_reg     <= b_kind_reg;
            o_raw_reg      <= b_raw_reg;
            o_scaled_reg   <= b_scaled;
            o_recorded_reg <= b_recorded;
        end
    end

    assign out.valid        = o_valid_reg;
    assign out.out_channel  = o_channel_reg;
    assign out.sensor_code  = o_code_reg;
    assign out.sensor_kind  = o_kind_reg;
    assign out.raw_value    = o_raw_reg;
    assign out.scaled_value = o_scaled_reg;
    assign out.recorded     = o_recorded_reg;

endmodule

[design/sensor_packet_deframer_core.sv]
// sensor packet deframer: per-channel sliding byte window, match and decode
// throughput: one byte per cycle unless out stalls, non-closing bytes take no pipeline slot
// a packet item is captured into stage a at the edge that takes its closing byte,
// then parsed and decoded into stage b, then rescaled by the multiply into the output register
// the window is a row of nine byte cells that shift once per non-closing byte of their channel
// reset: rst_n clears fill counts and pipeline valids at once, registers return to 323 and 24
module sensor_packet_deframer_core #(
    parameter int CHANNELS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    spd_in_if.sink                          in,
    spd_out_if.source                       out,
    input  logic                            cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spd_pkg::CFG_W-1:0]       cfg_data
);
    import spd_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [OFFSET_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RESET_OFFSET;
            gain_reg   <= RESET_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    offset_reg <= offset_reg;
            endcase
        end
    end

    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                accept;
    logic                frame_ready;
    logic                frame_valid;
    logic                full;
    logic                match;
    logic                shift_en;
    frame_t              frame;
    logic [FILL_W-1:0]   fill_reg [CHANNELS];
    logic [FILL_W-1:0]   fill_cur;
    byte_t               hist [HIST_BYTES];

    assign ch_ok    = int'(in.channel) < CHANNELS;
    assign ch_idx   = CH_IDX_W'(in.channel);
    assign in.ready = frame_ready;
    assign accept   = in.valid && frame_ready && ch_ok;
    assign fill_cur = fill_reg[ch_idx];
    assign full     = fill_cur == FILL_W'(HIST_BYTES);

    // the incoming byte is the tenth one, so '!' is checked on it directly
    assign match = full && (hist[0] == CHAR_A) && (hist[1] == CHAR_B)
                && (hist[2] == CHAR_A) && (in.data_byte == CHAR_BANG);
    assign shift_en    = accept && !match;
    assign frame_valid = accept && match;

    genvar k;
    generate
        for (k = 0; k < HIST_BYTES; k++)
        begin : g_cell
            byte_t cell_din;
            if (k == HIST_BYTES - 1)
            begin : g_last
                assign cell_din = in.data_byte;
            end
            else
            begin : g_mid
                assign cell_din = hist[k+1];
            end
            spd_cell #(
                .CHANNELS (CHANNELS),
                .CH_IDX_W (CH_IDX_W)
            ) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .ch_idx   (ch_idx),
                .din      (cell_din),
                .dout     (hist[k])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            if (match)
            begin
                fill_reg[ch_idx] <= '0;
            end
            else if (!full)
            begin
                fill_reg[ch_idx] <= fill_cur + FILL_W'(1);
            end
        end
    end

    always_comb
    begin
        frame.channel = in.channel;
        frame.code    = hist[CODE_POS];
        for (int i = 0; i < VALUE_DIGITS; i++)
        begin
            frame.chars[i] = hist[VALUE_POS+i];
        end
    end

    spd_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .scale_offset (offset_reg),
        .scale_gain   (gain_reg),
        .out          (out)
    );

endmodule

[design/spd_checker.sv]
// port-level checks of the sensor packet deframer, bound to the top level
module spd_checker #(
    parameter int CHANNELS = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic [spd_pkg::CH_W-1:0]             out_channel,
    input  logic [spd_pkg::KIND_W-1:0]           sensor_kind,
    input  logic signed [spd_pkg::RAW_W-1:0]     raw_value,
    input  logic signed [spd_pkg::SCALED_W-1:0]  scaled_value,
    input  logic                                 recorded
);
    import spd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_value)
                                    && $stable(scaled_value) && $stable(sensor_kind))
        else $error("stalled output item changed");

    a_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> recorded == ((sensor_kind == KIND_TEMP) || (sensor_kind == KIND_ACCEL)
                                || (sensor_kind == KIND_HUMID) || (sensor_kind == KIND_VOLT)))
        else $error("recorded flag does not follow kind");

    a_raw_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sensor_kind != KIND_TEMP) && (sensor_kind != KIND_ACCEL)
        && (sensor_kind != KIND_VOLT)
        |-> scaled_value == {{(SCALED_W-RAW_W){raw_value[RAW_W-1]}}, raw_value})
        else $error("unscaled kind does not pass raw value");

    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(out_channel) < CHANNELS)
        else $error("packet on a channel that takes no bytes");

endmodule

bind sensor_packet_deframer_core spd_checker #(
    .CHANNELS (CHANNELS)
) u_spd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out.valid),
    .out_ready    (out.ready),
    .out_channel  (out.out_channel),
    .sensor_kind  (out.sensor_kind),
    .raw_value    (out.raw_value),
    .scaled_value (out.scaled_value),
    .recorded     (out.recorded)
);
